### rtl/core/hpq_pkg.sv
// hpq_pkg: shared types and codes for the min-heap priority queue core
// no dependencies; used by the top level and the heap memory
package hpq_pkg;

  localparam int unsigned ValW = 32;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DEL_MIN = 2'd1,
    ACT_DEL_VAL = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_UP_CHK,
    S_UP_CMP,
    S_FIN,
    S_DONE
  } state_e;

  typedef logic [ValW-1:0] word_t;

endpackage

### rtl/core/hpq_mem.sv
// hpq_mem: heap entry storage, one write and one read port, registered read data
// depends on hpq_pkg for the word type
module hpq_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  hpq_pkg::word_t       wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output hpq_pkg::word_t       rdata_o
);

  hpq_pkg::word_t mem_q [Depth];
  hpq_pkg::word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/min_heap_priority_queue_core.sv
// min_heap_priority_queue_core: binary min-heap sequencer, result register and checks
// depends on hpq_pkg and hpq_mem
//
//  channel  | dir | tdata fields (low bit up)                       | width
//  s_axis   | in  | action[1:0], value[33:2]                        | 40
//  m_axis   | out | status, removed_value, min_value, entry_count   | bytes of 66+CntW
//
// one item at a time; a full or empty report skips to the result, other items
// first do their sift or scan work; insert: S_UP_CHK, S_UP_CMP per level climbed
// remove minimum: S_DN_CHK, S_DN_L and, with a right child, S_DN_R per level
// remove value: one slot per cycle through the memory read port, then the sifts
// the single read port sets the pace
// reset clears the fill count, the sequencer and the output valid only, the entries need no clearing
// a stalled result sits in the output register; the next beat is taken meanwhile
module min_heap_priority_queue_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // action[1:0], value[33:2], zero fill
  input  logic [39:0]                                s_axis_tdata_i,
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  // status[1:0], removed_value[33:2], min_value[65:34], entry_count above, zero fill
  output logic [((66+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OutW  = ((66 + CntW + 7) / 8) * 8;

  hpq_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;       // entries held
  logic [CntW-1:0]  pos_q, pos_d;       // hole slot of the moving entry
  logic [CntW-1:0]  start_q, start_d;   // slot where the sift began
  logic [CntW:0]    scan_q, scan_d;     // next slot to read in a search
  logic             pend_q, pend_d;     // a search read is in flight
  hpq_pkg::word_t   cur_q, cur_d;       // entry being sifted
  hpq_pkg::word_t   lv_q, lv_d;         // left child held while right is read
  hpq_pkg::word_t   val_q, val_d;       // search key
  hpq_pkg::word_t   root_q, root_d;     // copy of slot one
  hpq_pkg::word_t   rem_q, rem_d;
  hpq_pkg::status_e stat_q, stat_d;
  logic             out_vld_q, out_vld_d;
  logic [OutW-1:0]  out_q, out_d;

  logic             mem_we, mem_re;
  logic [CntW-1:0]  w_slot, r_slot, w_tmp, r_tmp;
  hpq_pkg::word_t   mem_wdata, rd_data;

  // slot k lives at address k-1
  assign w_tmp = w_slot - 1'b1;
  assign r_tmp = r_slot - 1'b1;

  hpq_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (w_tmp[AddrW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (r_tmp[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  // child slots and sift-down choice, left child wins a tie
  logic [CntW:0]    kid_l, kid_r, cnt_x;
  hpq_pkg::word_t   l_val;
  logic             take_l, take_r, r_ok;
  hpq_pkg::word_t   best_val;
  logic [CntW-1:0]  best_slot;
  logic [CntW-1:0]  found_slot;
  logic [CntW:0]    found_tmp;
  logic             out_free;

  assign kid_l      = {pos_q, 1'b0};
  assign kid_r      = kid_l + 1'b1;
  assign cnt_x      = {1'b0, cnt_q};
  assign found_tmp  = scan_q - 1'b1;
  assign found_slot = found_tmp[CntW-1:0];
  assign out_free   = !out_vld_q || m_axis_tready_i;

  always_comb begin
    r_ok   = (state_q == hpq_pkg::S_DN_R);
    l_val  = r_ok ? lv_q : rd_data;
    take_l = ($signed(l_val) < $signed(cur_q));
    take_r = r_ok && ($signed(rd_data) < $signed(take_l ? l_val : cur_q));
    if (take_r) begin
      best_val  = rd_data;
      best_slot = kid_r[CntW-1:0];
    end else begin
      best_val  = l_val;
      best_slot = kid_l[CntW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    start_d   = start_q;
    scan_d    = scan_q;
    pend_d    = 1'b0;
    cur_d     = cur_q;
    lv_d      = lv_q;
    val_d     = val_q;
    rem_d     = rem_q;
    stat_d    = stat_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    w_slot    = pos_q;
    r_slot    = cnt_q;
    mem_wdata = cur_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    out_d     = out_q;
    s_axis_tready_o = (state_q == hpq_pkg::S_IDLE);

    unique case (state_q)
      hpq_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          val_d  = s_axis_tdata_i[33:2];
          rem_d  = '0;
          stat_d = hpq_pkg::STAT_OK;
          unique case (hpq_pkg::action_e'(s_axis_tdata_i[1:0]))
            hpq_pkg::ACT_INSERT: begin
              if (cnt_q == CntW'(CAPACITY)) begin
                stat_d  = hpq_pkg::STAT_FULL;
                state_d = hpq_pkg::S_DONE;
              end else begin
                cnt_d   = cnt_q + 1'b1;
                pos_d   = cnt_q + 1'b1;
                cur_d   = s_axis_tdata_i[33:2];
                state_d = hpq_pkg::S_UP_CHK;
              end
            end
            hpq_pkg::ACT_DEL_MIN: begin
              if (cnt_q == '0) begin
                stat_d  = hpq_pkg::STAT_EMPTY;
                state_d = hpq_pkg::S_DONE;
              end else begin
                rem_d   = root_q;
                mem_re  = 1'b1;
                pos_d   = CntW'(1);
                start_d = CntW'(1);
                state_d = hpq_pkg::S_LAST;
              end
            end
            hpq_pkg::ACT_DEL_VAL: begin
              scan_d  = (CntW+1)'(1);
              state_d = hpq_pkg::S_SCAN;
            end
            default: state_d = hpq_pkg::S_DONE;
          endcase
        end
      end
      hpq_pkg::S_SCAN: begin
        if (pend_q && rd_data == val_q) begin
          rem_d = val_q;
          if (found_slot == cnt_q) begin
            cnt_d   = cnt_q - 1'b1;
            state_d = hpq_pkg::S_DONE;
          end else begin
            mem_re  = 1'b1;
            pos_d   = found_slot;
            start_d = found_slot;
            state_d = hpq_pkg::S_LAST;
          end
        end else if (scan_q <= cnt_x) begin
          mem_re = 1'b1;
          r_slot = scan_q[CntW-1:0];
          scan_d = scan_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          stat_d  = hpq_pkg::STAT_NOTFOUND;
          state_d = hpq_pkg::S_DONE;
        end
      end
      hpq_pkg::S_LAST: begin
        cur_d   = rd_data;
        cnt_d   = cnt_q - 1'b1;
        state_d = hpq_pkg::S_DN_CHK;
      end
      hpq_pkg::S_DN_CHK: begin
        if (kid_l <= cnt_x) begin
          mem_re  = 1'b1;
          r_slot  = kid_l[CntW-1:0];
          state_d = hpq_pkg::S_DN_L;
        end else begin
          state_d = (pos_q == start_q) ? hpq_pkg::S_UP_CHK : hpq_pkg::S_FIN;
        end
      end
      hpq_pkg::S_DN_L, hpq_pkg::S_DN_R: begin
        if (!r_ok && kid_r <= cnt_x) begin
          lv_d    = rd_data;
          mem_re  = 1'b1;
          r_slot  = kid_r[CntW-1:0];
          state_d = hpq_pkg::S_DN_R;
        end else if (take_l || take_r) begin
          // child moves up into the hole
          mem_we    = 1'b1;
          mem_wdata = best_val;
          pos_d     = best_slot;
          state_d   = hpq_pkg::S_DN_CHK;
        end else begin
          state_d = (pos_q == start_q) ? hpq_pkg::S_UP_CHK : hpq_pkg::S_FIN;
        end
      end
      hpq_pkg::S_UP_CHK: begin
        if (pos_q > CntW'(1)) begin
          mem_re  = 1'b1;
          r_slot  = pos_q >> 1;
          state_d = hpq_pkg::S_UP_CMP;
        end else begin
          state_d = hpq_pkg::S_FIN;
        end
      end
      hpq_pkg::S_UP_CMP: begin
        if ($signed(cur_q) < $signed(rd_data)) begin
          // parent moves down into the hole
          mem_we    = 1'b1;
          mem_wdata = rd_data;
          pos_d     = pos_q >> 1;
          state_d   = hpq_pkg::S_UP_CHK;
        end else begin
          state_d = hpq_pkg::S_FIN;
        end
      end
      hpq_pkg::S_FIN: begin
        mem_we  = 1'b1;
        state_d = hpq_pkg::S_DONE;
      end
      hpq_pkg::S_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = '0;
          out_d[1:0]         = stat_q;
          out_d[33:2]        = rem_q;
          out_d[65:34]       = (cnt_q != '0) ? root_q : '0;
          out_d[66+:CntW]    = cnt_q;
          state_d   = hpq_pkg::S_IDLE;
        end
      end
      default: state_d = hpq_pkg::S_IDLE;
    endcase
  end

  // keep the root copy in step with every write of slot one
  assign root_d = (mem_we && w_slot == CntW'(1)) ? mem_wdata : root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hpq_pkg::S_IDLE;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    start_q <= start_d;
    scan_q  <= scan_d;
    cur_q   <= cur_d;
    lv_q    <= lv_d;
    val_q   <= val_d;
    root_q  <= root_d;
    rem_q   <= rem_d;
    stat_q  <= stat_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // fill count never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  // a read and a write never hit the same slot in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (w_slot != r_slot))
    else $error("read and write collide on one slot");

  // an empty heap reports a zero minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_q[66+:CntW] == '0) |-> (out_q[65:34] == '0))
    else $error("nonzero minimum on empty heap");

  // full status only with the heap at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_q[1:0] == hpq_pkg::STAT_FULL) |->
      (out_q[66+:CntW] == CntW'(CAPACITY)))
    else $error("full status below capacity");

endmodule

### test/testbench.sv
// testbench: random and directed check of the min-heap priority queue core
// depends on hpq_pkg and min_heap_priority_queue_core; heap predictor in a scoreboard class
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned Cap = 16;
  localparam int unsigned CntW = $clog2(Cap + 1);
  localparam int unsigned OutW = ((66 + CntW + 7) / 8) * 8;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [CntW-1:0] count;
    logic [31:0]     min_val;
    logic [31:0]     removed;
    logic [1:0]      status;
  } heap_result_t;

  class heap_scoreboard;
    logic signed [31:0] slots [1:Cap];
    int unsigned fill;
    heap_result_t pending [$];
    int unsigned errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic signed [31:0] t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    function void sift_up(int unsigned p);
      while (p > 1 && p <= fill && slots[p] < slots[p/2]) begin
        swap_slots(p, p / 2);
        p = p / 2;
      end
    endfunction

    function void sift_down(int unsigned p);
      int unsigned kid;
      int unsigned best;
      while (p >= 1 && 2 * p <= fill) begin
        kid = 2 * p;
        best = p;
        if (slots[kid] < slots[best]) best = kid;
        if (kid + 1 <= fill && slots[kid+1] < slots[best]) best = kid + 1;
        if (best == p) break;
        swap_slots(p, best);
        p = best;
      end
    endfunction

    // apply one accepted beat to the model heap and queue its result
    function void note_beat(hpq_pkg::action_e act, logic signed [31:0] val);
      heap_result_t r;
      int unsigned p;
      r = '0;
      r.status = hpq_pkg::STAT_OK;
      case (act)
        hpq_pkg::ACT_INSERT: begin
          if (fill >= Cap) r.status = hpq_pkg::STAT_FULL;
          else begin
            fill++;
            slots[fill] = val;
            sift_up(fill);
          end
        end
        hpq_pkg::ACT_DEL_MIN: begin
          if (fill == 0) r.status = hpq_pkg::STAT_EMPTY;
          else begin
            r.removed = slots[1];
            slots[1] = slots[fill];
            fill--;
            sift_down(1);
          end
        end
        hpq_pkg::ACT_DEL_VAL: begin
          p = 1;
          while (p <= fill && slots[p] != val) p++;
          if (p > fill) r.status = hpq_pkg::STAT_NOTFOUND;
          else begin
            r.removed = slots[p];
            slots[p] = slots[fill];
            fill--;
            if (p <= fill) begin
              sift_down(p);
              sift_up(p);
            end
          end
        end
        default: ;
      endcase
      r.min_val = (fill != 0) ? slots[1] : 32'd0;
      r.count = CntW'(fill);
      pending.push_back(r);
    endfunction

    function void check_beat(heap_result_t got);
      heap_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.removed !== want.removed ||
          got.min_val !== want.min_val || got.count !== want.count) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d rm=%0d min=%0d cnt=%0d got st=%0d rm=%0d min=%0d cnt=%0d",
                   want.status, $signed(want.removed), $signed(want.min_val), want.count,
                   got.status, $signed(got.removed), $signed(got.min_val), got.count);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic s_valid;
  logic s_ready;
  logic [39:0] s_data;
  logic m_valid;
  logic m_ready;
  logic [OutW-1:0] m_data;
  bit idle_free;
  heap_scoreboard board;

  min_heap_priority_queue_core #(.CAPACITY(Cap)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stall, check at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid && m_ready)
        board.check_beat(heap_result_t'(m_data[66+CntW-1:0]));
      m_ready <= idle_free || ($urandom_range(99) >= 28);
    end else begin
      m_ready <= 1'b0;
    end
  end

  // drive one beat, with a random gap first; valid stays up until the next gap or drain
  task automatic send_beat(hpq_pkg::action_e act, logic [31:0] val);
    while (!idle_free && $urandom_range(99) < 28) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {6'd0, val, act};
    do @(posedge clk_i); while (!s_ready);
    board.note_beat(act, val);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] last_val);
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return last_val;
      default: return 32'($urandom_range(40)) - 32'd20;
    endcase
  endfunction

  initial begin
    logic [31:0] v;
    logic [31:0] last_val;
    int unsigned r;
    hpq_pkg::action_e act;
    board = new();
    s_valid = 1'b0;
    s_data = '0;
    idle_free = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty removals, unused code, extremes, full heap, last-slot removal
    send_beat(hpq_pkg::ACT_DEL_MIN, 32'd0);
    send_beat(hpq_pkg::ACT_DEL_VAL, 32'd5);
    send_beat(hpq_pkg::ACT_NONE, 32'hffff_ffff);
    send_beat(hpq_pkg::ACT_INSERT, 32'h7fff_ffff);
    send_beat(hpq_pkg::ACT_INSERT, 32'h8000_0000);
    send_beat(hpq_pkg::ACT_DEL_VAL, 32'h7fff_ffff);
    send_beat(hpq_pkg::ACT_DEL_VAL, 32'h1234_5678);
    for (int i = 0; i < 17; i++)
      send_beat(hpq_pkg::ACT_INSERT, 32'(i * 7 % 11) - 32'd5);
    send_beat(hpq_pkg::ACT_DEL_MIN, 32'hffff_ffff);
    drain();

    // random: well-formed mix biased by phase so the heap sweeps empty to full
    last_val = 0;
    for (int n = 0; n < 1500; n++) begin
      idle_free = (n >= 400 && n < 600);
      if (n == 900) drain();
      r = $urandom_range(99);
      if (r < 3) act = hpq_pkg::ACT_NONE;
      else if (r < (((n / 200) % 2) ? 70 : 35)) act = hpq_pkg::ACT_INSERT;
      else if (r < 75) act = hpq_pkg::ACT_DEL_MIN;
      else act = hpq_pkg::ACT_DEL_VAL;
      v = pick_value(last_val);
      if (act == hpq_pkg::ACT_DEL_VAL && board.fill != 0 && $urandom_range(3) != 0)
        v = board.slots[$urandom_range(board.fill, 1)];
      if (act == hpq_pkg::ACT_INSERT) last_val = v;
      send_beat(act, v);
    end
    idle_free = 1'b0;
    drain();
    repeat (50) @(posedge clk_i);
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
